>>> rtl/core/aest_pkg.sv
`default_nettype none
package aest_pkg;

  // sensor and field widths
  localparam int RAW_ANGLE_W   = 14;
  localparam int ANGLE_BITS_D  = 14;
  localparam int SCALE_W       = 24;
  localparam int SPEED_W       = 16;
  localparam int TICK_W        = 32;
  localparam int CFG_INDEX_W   = 4;
  localparam int CFG_DATA_W    = 24;

  // speed scale is Q16
  localparam int SCALE_FRAC_W  = 16;

  // configuration reset values
  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 24'd920;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_SCALE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE     = 4'd1;

  // item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PROBE  = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [RAW_ANGLE_W-1:0] raw_angle;
    logic                   access_ok;
  } aest_in_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_mm_s;
    logic signed [TICK_W-1:0]  tick_total;
    logic                      online;
  } aest_out_t;

  typedef struct packed {
    logic [SCALE_W-1:0] speed_scale;
    logic               reverse_direction;
  } aest_cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/aest_speed.sv
`default_nettype none
module aest_speed #(
  parameter int ANGLE_BITS = aest_pkg::ANGLE_BITS_D
) (
  input  wire logic signed [ANGLE_BITS:0]             delta,
  input  wire logic [aest_pkg::SCALE_W-1:0]           speed_scale,
  output logic signed [aest_pkg::SPEED_W-1:0]         speed
);
  import aest_pkg::*;

  localparam int PROD_W = ANGLE_BITS + SCALE_W;
  localparam int Q_W    = PROD_W + 1 - SCALE_FRAC_W;

  logic [ANGLE_BITS:0]   delta_neg;
  logic [ANGLE_BITS-1:0] mag;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W:0]       rounded;
  logic [Q_W-1:0]        q;
  logic [SPEED_W-1:0]    q_low;

  // magnitude of the delta, at most half a turn
  assign delta_neg = -delta;
  assign mag = delta[ANGLE_BITS] ? delta_neg[ANGLE_BITS-1:0] : delta[ANGLE_BITS-1:0];

  // scale, round half away from zero on the magnitude
  assign prod    = PROD_W'(mag) * PROD_W'(speed_scale);
  assign rounded = (PROD_W + 1)'(prod) + (PROD_W + 1)'(1 << (SCALE_FRAC_W - 1));
  assign q       = rounded[PROD_W:SCALE_FRAC_W];
  assign q_low   = q[SPEED_W-1:0];

  // restore sign and saturate to int16
  always_comb begin
    if (delta[ANGLE_BITS]) begin
      if (q > Q_W'(32768)) speed = $signed(16'h8000);
      else                 speed = $signed(-q_low);
    end else begin
      if (q > Q_W'(32767)) speed = $signed(16'h7fff);
      else                 speed = $signed(q_low);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/aest_track.sv
`default_nettype none
module aest_track #(
  parameter int ANGLE_BITS = aest_pkg::ANGLE_BITS_D
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire aest_pkg::aest_in_t  item,
  input  wire aest_pkg::aest_cfg_t cfg,
  output aest_pkg::aest_out_t      result
);
  import aest_pkg::*;

  localparam int TURN = 1 << ANGLE_BITS;
  localparam int HALF = TURN / 2;
  localparam logic signed [ANGLE_BITS:0] TURN_S     = (ANGLE_BITS + 1)'(TURN);
  localparam logic signed [ANGLE_BITS:0] HALF_S     = (ANGLE_BITS + 1)'(HALF);
  localparam logic signed [ANGLE_BITS:0] NEG_HALF_S = -HALF_S;

  logic [ANGLE_BITS-1:0] prev_angle_r, prev_angle_nxt;
  logic                  prev_valid_r, prev_valid_nxt;
  logic                  online_r, online_nxt;
  logic [TICK_W-1:0]     ticks_r, ticks_nxt;

  logic [ANGLE_BITS-1:0]        angle;
  logic signed [ANGLE_BITS:0]   diff;
  logic signed [ANGLE_BITS:0]   delta_unw;
  logic signed [ANGLE_BITS:0]   delta;
  logic signed [SPEED_W-1:0]    speed_calc;
  logic signed [SPEED_W-1:0]    speed;

  // take the low angle bits of the raw sample, or zero-extend it when the angle is wider
  generate
    if (ANGLE_BITS <= RAW_ANGLE_W) begin : g_trunc
      assign angle = item.raw_angle[ANGLE_BITS-1:0];
    end else begin : g_ext
      assign angle = {{(ANGLE_BITS - RAW_ANGLE_W){1'b0}}, item.raw_angle};
    end
  endgenerate

  // unwrap across the full-turn boundary, half turn kept as is
  assign diff = $signed({1'b0, angle}) - $signed({1'b0, prev_angle_r});

  always_comb begin
    if (diff > HALF_S)           delta_unw = diff - TURN_S;
    else if (diff < NEG_HALF_S)  delta_unw = diff + TURN_S;
    else                         delta_unw = diff;
  end

  assign delta = cfg.reverse_direction ? -delta_unw : delta_unw;

  aest_speed #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_speed (
    .delta       (delta),
    .speed_scale (cfg.speed_scale),
    .speed       (speed_calc)
  );

  // per-transaction state update
  always_comb begin
    prev_angle_nxt = prev_angle_r;
    prev_valid_nxt = prev_valid_r;
    online_nxt     = online_r;
    ticks_nxt      = ticks_r;
    speed          = '0;
    if (item.op == OP_SAMPLE) begin
      if (online_r) begin
        if (!item.access_ok) begin
          online_nxt = 1'b0;
        end else if (!prev_valid_r) begin
          prev_angle_nxt = angle;
          prev_valid_nxt = 1'b1;
        end else begin
          prev_angle_nxt = angle;
          ticks_nxt      = ticks_r + TICK_W'(delta);
          speed          = speed_calc;
        end
      end
    end else begin
      if (!online_r && item.access_ok) begin
        online_nxt     = 1'b1;
        prev_valid_nxt = 1'b0;
      end
    end
  end

  assign result.speed_mm_s = speed;
  assign result.tick_total = $signed(ticks_nxt);
  assign result.online     = online_nxt;

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      prev_valid_r <= 1'b0;
      online_r     <= 1'b0;
      ticks_r      <= '0;
    end else if (step) begin
      prev_angle_r <= prev_angle_nxt;
      prev_valid_r <= prev_valid_nxt;
      online_r     <= online_nxt;
      ticks_r      <= ticks_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/absolute_encoder_tick_speed_tracker.sv
// An accepted transaction goes into the input stage register, and its result into
// the result register when that is empty or out_ready is high; out_valid follows it.
// One transaction per cycle unless out_ready stalls the result register; the
// unwrap, tick add and speed multiply are combinational between the registers.
// Reset (rst_n low, synchronous): channel offline, no previous angle, tick
// total zero, speed_scale 920, reverse_direction 0, both pipeline stages empty.
`default_nettype none
module absolute_encoder_tick_speed_tracker #(
  parameter int ANGLE_BITS = aest_pkg::ANGLE_BITS_D
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire aest_pkg::aest_in_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output aest_pkg::aest_out_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [aest_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [aest_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import aest_pkg::*;

  logic       s0_valid_r, s0_valid_nxt;
  aest_in_t   s0_data_r;
  logic       out_valid_r, out_valid_nxt;
  aest_out_t  out_data_r;
  aest_cfg_t  cfg_r, cfg_nxt;
  aest_out_t  result;
  logic       advance;
  logic       step;

  // pipeline flow control
  assign advance  = !out_valid_r || out_ready;
  assign step     = s0_valid_r && advance;
  assign in_ready = !s0_valid_r || advance;

  assign s0_valid_nxt  = (in_valid && in_ready) ? 1'b1 : (step ? 1'b0 : s0_valid_r);
  assign out_valid_nxt = advance ? s0_valid_r : out_valid_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SPEED_SCALE: cfg_nxt.speed_scale       = cfg_data[SCALE_W-1:0];
        CFG_REVERSE:     cfg_nxt.reverse_direction = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  aest_track #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s0_data_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{speed_scale: SPEED_SCALE_RST, reverse_direction: 1'b0};
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> tb/encoder_track_checker.sv
`default_nettype none
module encoder_track_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire aest_pkg::aest_in_t               in_data,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire aest_pkg::aest_out_t              out_data,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [aest_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [aest_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                    mismatch_count,
  output int                                    reports_outstanding
);
  import aest_pkg::*;

  localparam int FULL_TURN = 1 << ANGLE_BITS_D;
  localparam int HALF_TURN = FULL_TURN / 2;

  // tracker state and register copies
  logic [ANGLE_BITS_D-1:0] last_angle;
  logic                    have_last;
  logic                    link_up;
  logic [TICK_W-1:0]       tick_sum;
  logic [SCALE_W-1:0]      scale_q16;
  logic                    reverse_dir;

  aest_out_t expected_reports[$];
  aest_out_t want;
  int        errors = 0;

  // one input transaction: update the tracker and build its report
  function automatic aest_out_t advance_tracker(input aest_in_t item);
    aest_out_t                 rpt;
    int                        delta;
    logic [63:0]               magnitude;
    logic [63:0]               rounded;
    logic [SPEED_W-1:0]        speed;
    logic [ANGLE_BITS_D-1:0]   angle;
    angle = item.raw_angle[ANGLE_BITS_D-1:0];
    speed = '0;
    if (item.op == OP_SAMPLE) begin
      if (link_up) begin
        if (!item.access_ok) begin
          link_up = 1'b0;
        end else if (!have_last) begin
          // priming sample after coming online
          last_angle = angle;
          have_last  = 1'b1;
        end else begin
          // unwrap across the full turn, exact half turn kept as is
          delta = int'(angle) - int'(last_angle);
          if (delta > HALF_TURN) begin
            delta -= FULL_TURN;
          end else if (delta < -HALF_TURN) begin
            delta += FULL_TURN;
          end
          last_angle = angle;
          if (reverse_dir) begin
            delta = -delta;
          end
          tick_sum  = tick_sum + delta;
          // q16 scale, round half away from zero, saturate to int16
          magnitude = 64'((delta < 0) ? -delta : delta);
          rounded   = (magnitude * 64'(scale_q16) + 64'd32768) >> SCALE_FRAC_W;
          if (delta < 0) begin
            speed = (rounded > 64'd32768) ? 16'h8000 : 16'(64'd0 - rounded);
          end else begin
            speed = (rounded > 64'd32767) ? 16'h7fff : rounded[15:0];
          end
        end
      end
    end else if (!link_up && item.access_ok) begin
      // successful probe while offline reconnects
      link_up   = 1'b1;
      have_last = 1'b0;
    end
    rpt.speed_mm_s = speed;
    rpt.tick_total = tick_sum;
    rpt.online     = link_up;
    return rpt;
  endfunction

  task automatic report_mismatch(input string field, input logic signed [63:0] wanted,
                                 input logic signed [63:0] seen);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, seen);
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      last_angle  = '0;
      have_last   = 1'b0;
      link_up     = 1'b0;
      tick_sum    = '0;
      scale_q16   = SPEED_SCALE_RST;
      reverse_dir = 1'b0;
      expected_reports.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEED_SCALE: scale_q16 = cfg_data[SCALE_W-1:0];
          CFG_REVERSE:     reverse_dir = cfg_data[0];
          default: ;
        endcase
      end
      // result transaction against the oldest report
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, speed %0d ticks %0d online %0b", $time,
                   out_data.speed_mm_s, out_data.tick_total, out_data.online);
        end else begin
          want = expected_reports.pop_front();
          if (out_data.speed_mm_s !== want.speed_mm_s) begin
            report_mismatch("speed_mm_s", want.speed_mm_s, out_data.speed_mm_s);
          end
          if (out_data.tick_total !== want.tick_total) begin
            report_mismatch("tick_total", want.tick_total, out_data.tick_total);
          end
          if (out_data.online !== want.online) begin
            report_mismatch("online", {63'd0, want.online}, {63'd0, out_data.online});
          end
        end
      end
      // input transaction
      if (in_valid && in_ready) begin
        expected_reports.push_back(advance_tracker(in_data));
      end
    end
    mismatch_count      <= errors;
    reports_outstanding <= expected_reports.size();
  end

endmodule
`default_nettype wire

>>> tb/absolute_encoder_tick_speed_tracker_test.sv
`default_nettype none
module absolute_encoder_tick_speed_tracker_test;
  import aest_pkg::*;

  localparam int RAW_W           = RAW_ANGLE_W;
  localparam int ANGLE_MAX       = (1 << RAW_W) - 1;
  localparam int HALF_SPAN       = 1 << (RAW_W - 1);
  localparam int PHASES          = 7;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int RAMP_STEPS      = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  aest_in_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  aest_out_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatch_count;
  int reports_outstanding;
  int quiet_cycles = 0;
  int hold_requests = 0;
  bit fast = 1'b0;
  bit link_lost = 1'b0;
  logic [RAW_W-1:0] stim_angle = '0;

  logic [SCALE_W-1:0] phase_scale [PHASES] =
    '{24'hffffff, 24'd0, 24'd8388608, 24'd32768, 24'd920, 24'd1, 24'd65536};
  bit phase_rev [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  always #5 clk = ~clk;

  absolute_encoder_tick_speed_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  encoder_track_checker track_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .reports_outstanding (reports_outstanding)
  );

  function automatic aest_in_t make_item(input logic op, input int angle, input logic ok);
    aest_in_t item;
    item.op        = op;
    item.raw_angle = angle[RAW_W-1:0];
    item.access_ok = ok;
    return item;
  endfunction

  // offer one transaction after a random gap, return at the falling edge after acceptance
  task automatic push_item(input aest_in_t item);
    int gap;
    gap = fast ? 0 : $urandom_range(7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (reports_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // both registers back to back, valid held high across the pair
  task automatic load_config(input logic [SCALE_W-1:0] scale, input logic rev);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SPEED_SCALE;
    cfg_data  <= scale;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_REVERSE;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, rev};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly good samples that move by small or large steps, some failures and probes
  task automatic next_random_item(output aest_in_t item);
    int pick;
    int delta;
    pick = $urandom_range(99);
    item.op        = OP_SAMPLE;
    item.access_ok = 1'b1;
    item.raw_angle = RAW_W'($urandom_range(ANGLE_MAX));
    if (link_lost && pick < 70) begin
      // reconnect after a failed read
      item.op   = OP_PROBE;
      link_lost = 1'b0;
    end else if (pick < 45) begin
      delta          = int'($urandom_range(64)) - 32;
      stim_angle     = stim_angle + delta[RAW_W-1:0];
      item.raw_angle = stim_angle;
    end else if (pick < 65) begin
      delta          = int'($urandom_range(2 * HALF_SPAN)) - HALF_SPAN;
      stim_angle     = stim_angle + delta[RAW_W-1:0];
      item.raw_angle = stim_angle;
    end else if (pick < 80) begin
      stim_angle = item.raw_angle;
    end else if (pick < 86) begin
      item.access_ok = 1'b0;
      link_lost      = 1'b1;
    end else if (pick < 94) begin
      item.op        = OP_PROBE;
      item.access_ok = 1'($urandom_range(1));
    end else begin
      item.op        = 1'($urandom_range(1));
      item.access_ok = 1'($urandom_range(1));
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int hold_served;
    int pause;
    hold_served = 0;
    out_ready   = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_served < hold_requests) begin
        pause = HOLD_OFF_CYCLES;
        hold_served++;
      end else begin
        pause = fast ? 0 : $urandom_range(7);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL absolute_encoder_tick_speed_tracker");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    aest_in_t           item;
    logic [RAW_W-1:0]   ramp_angle;
    logic [SCALE_W-1:0] scale;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: offline handling, priming, half-turn and wrap cases at reset config
    push_item(make_item(OP_SAMPLE, 100, 1'b1));
    push_item(make_item(OP_SAMPLE, ANGLE_MAX, 1'b0));
    push_item(make_item(OP_PROBE, 0, 1'b0));
    push_item(make_item(OP_PROBE, ANGLE_MAX, 1'b1));
    push_item(make_item(OP_PROBE, 0, 1'b1));
    push_item(make_item(OP_PROBE, 0, 1'b0));
    push_item(make_item(OP_SAMPLE, 0, 1'b1));
    push_item(make_item(OP_SAMPLE, ANGLE_MAX, 1'b1));
    push_item(make_item(OP_SAMPLE, HALF_SPAN - 1, 1'b1));
    push_item(make_item(OP_SAMPLE, 0, 1'b1));
    push_item(make_item(OP_SAMPLE, HALF_SPAN, 1'b1));
    push_item(make_item(OP_SAMPLE, 0, 1'b1));
    push_item(make_item(OP_SAMPLE, ANGLE_MAX, 1'b0));
    push_item(make_item(OP_SAMPLE, 5, 1'b1));
    push_item(make_item(OP_PROBE, 0, 1'b1));
    push_item(make_item(OP_SAMPLE, ANGLE_MAX, 1'b1));
    push_item(make_item(OP_SAMPLE, 0, 1'b1));
    push_item(make_item(OP_SAMPLE, 10000, 1'b1));
    push_item(make_item(OP_SAMPLE, 1, 1'b1));

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      scale = (p == 4) ? SCALE_W'($urandom_range(24'hffffff)) : phase_scale[p];
      load_config(scale, phase_rev[p]);
      // reconnect, prime, then full swings and the int16 edge
      push_item(make_item(OP_PROBE, 0, 1'b1));
      push_item(make_item(OP_SAMPLE, 0, 1'b1));
      push_item(make_item(OP_SAMPLE, HALF_SPAN, 1'b1));
      push_item(make_item(OP_SAMPLE, 0, 1'b1));
      push_item(make_item(OP_SAMPLE, 256, 1'b1));
      push_item(make_item(OP_SAMPLE, 0, 1'b1));
      stim_angle = '0;
      link_lost  = 1'b0;

      // back-to-back ramp of +8191 per sample, no gaps on either side
      if (p == 4) begin
        fast       = 1'b1;
        ramp_angle = '0;
        for (int n = 0; n < RAMP_STEPS; n++) begin
          ramp_angle = ramp_angle + RAW_W'(HALF_SPAN - 1);
          push_item(make_item(OP_SAMPLE, int'(ramp_angle), 1'b1));
        end
        fast       = 1'b0;
        stim_angle = ramp_angle;
      end

      if (p == 1) begin
        hold_requests++;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 3 && n == RANDOM_PER_PHASE / 2) begin
          drain_results();
        end
        next_random_item(item);
        push_item(item);
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && reports_outstanding == 0) begin
      $display("PASS absolute_encoder_tick_speed_tracker");
    end else begin
      $display("FAIL absolute_encoder_tick_speed_tracker");
    end
    $finish;
  end

endmodule
`default_nettype wire
